// ===== hw/rtl/cps_pkg.sv =====
// Shared constants, command codes, phase codes and saturation helper for the climb sequencer.
package cps_pkg;

  // Encoder and target width.
  localparam int POSITION_BITS = 24;

  // Fixed widths of the configuration registers, the wait counter and the configuration port.
  localparam int CFG_POS_BITS  = 24;
  localparam int STEP_BITS     = 17;
  localparam int WAIT_CFG_BITS = 8;
  localparam int TOL_BITS      = 16;
  localparam int WAIT_BITS     = 9;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 24;

  // Working width for target arithmetic: room for the widest operand plus sum and sign.
  localparam int WIDE = ((POSITION_BITS > CFG_POS_BITS) ? POSITION_BITS : CFG_POS_BITS) + 2;

  localparam logic [WAIT_BITS-1:0] WAIT_MAX = '1;

  // Command codes.
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_MOVE = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;
  localparam logic [1:0] CMD_ZERO = 2'd3;

  // Phase codes.
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_RELEASE    = 3'd1;
  localparam logic [2:0] PH_WAIT       = 3'd2;
  localparam logic [2:0] PH_EXTEND     = 3'd3;
  localparam logic [2:0] PH_HOLD       = 3'd4;
  localparam logic [2:0] PH_RETRACT    = 3'd5;
  localparam logic [2:0] PH_HOLD_AGAIN = 3'd6;
  localparam logic [2:0] PH_STEP       = 3'd7;

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE_POS  = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXTEND_POS   = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RETRACT_POS  = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEEPEST_POS  = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP_DELTA   = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_WAIT_TICKS   = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_NEAR_TOL     = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAR_TOL      = 4'd7;

  // Register reset values.
  localparam logic signed [CFG_POS_BITS-1:0] RST_RELEASE_POS = 24'sd600;
  localparam logic signed [CFG_POS_BITS-1:0] RST_EXTEND_POS  = -24'sd20000;
  localparam logic signed [CFG_POS_BITS-1:0] RST_RETRACT_POS = -24'sd25000;
  localparam logic signed [CFG_POS_BITS-1:0] RST_DEEPEST_POS = -24'sd29000;
  localparam logic signed [STEP_BITS-1:0]    RST_STEP_DELTA  = -17'sd500;
  localparam logic [WAIT_CFG_BITS-1:0]       RST_WAIT_TICKS  = 8'd25;
  localparam logic [TOL_BITS-1:0]            RST_NEAR_TOL    = 16'd300;
  localparam logic [TOL_BITS-1:0]            RST_FAR_TOL     = 16'd1000;

  localparam logic signed [WIDE-1:0] POS_MAX_W =
    {{(WIDE-POSITION_BITS+1){1'b0}}, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [WIDE-1:0] POS_MIN_W =
    {{(WIDE-POSITION_BITS+1){1'b1}}, {(POSITION_BITS-1){1'b0}}};

  // Clamp a working-width value to the signed position range.
  function automatic logic signed [POSITION_BITS-1:0] sat_pos(input logic signed [WIDE-1:0] v);
    logic signed [WIDE-1:0] c;
    begin
      c = v;
      if (v > POS_MAX_W) c = POS_MAX_W;
      if (v < POS_MIN_W) c = POS_MIN_W;
      sat_pos = c[POSITION_BITS-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/climb_position_sequencer.sv =====
// Top level of the winch-climb position sequencer: input register, phase update, result register.
//
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_ready    kind, retract_pressed, retract_released, position
// out      source     out_valid / out_ready  command, left_target, right_target, phase_out
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// Each request yields exactly one result: it waits in the input register, then passes
// through the phase logic into the result register. While out_ready is high, the
// sustained rate is one request per cycle; the phase update is a single short pass.
// A stalled result holds in the result register while one more request waits in the
// input register; in_ready drops only when both are full and out_ready is low.
// Synchronous reset clears phase, wait counter, target and valid flags; presets config registers.
module climb_position_sequencer (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    kind,
  input  logic                                    retract_pressed,
  input  logic                                    retract_released,
  input  logic signed [cps_pkg::POSITION_BITS-1:0] position,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [1:0]                              command,
  output logic signed [cps_pkg::POSITION_BITS-1:0] left_target,
  output logic signed [cps_pkg::POSITION_BITS-1:0] right_target,
  output logic [2:0]                              phase_out,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [cps_pkg::CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [cps_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

  localparam int PB = cps_pkg::POSITION_BITS;
  localparam int W  = cps_pkg::WIDE;

  typedef enum logic [2:0] {
    IDLE       = cps_pkg::PH_IDLE,
    RELEASE    = cps_pkg::PH_RELEASE,
    WAIT       = cps_pkg::PH_WAIT,
    EXTEND     = cps_pkg::PH_EXTEND,
    HOLD       = cps_pkg::PH_HOLD,
    RETRACT    = cps_pkg::PH_RETRACT,
    HOLD_AGAIN = cps_pkg::PH_HOLD_AGAIN,
    STEP       = cps_pkg::PH_STEP
  } phase_t;

  // Configuration registers.
  logic signed [cps_pkg::CFG_POS_BITS-1:0]  release_position;
  logic signed [cps_pkg::CFG_POS_BITS-1:0]  extend_position;
  logic signed [cps_pkg::CFG_POS_BITS-1:0]  retract_position;
  logic signed [cps_pkg::CFG_POS_BITS-1:0]  deepest_position;
  logic signed [cps_pkg::STEP_BITS-1:0]     step_delta;
  logic [cps_pkg::WAIT_CFG_BITS-1:0]        release_wait_ticks;
  logic [cps_pkg::TOL_BITS-1:0]             near_tolerance;
  logic [cps_pkg::TOL_BITS-1:0]             far_tolerance;

  // Input register.
  logic                 req_valid;
  logic                 req_kind;
  logic                 req_pressed;
  logic                 req_released;
  logic signed [PB-1:0] req_position;

  // Sequencer state.
  phase_t                          phase, phase_next;
  logic [cps_pkg::WAIT_BITS-1:0]   wait_count, wait_count_next;
  logic signed [PB-1:0]            current_target, current_target_next;

  logic                 advance;
  logic [1:0]           cmd_next;
  logic signed [W-1:0]  move;
  logic signed [W-1:0]  diff, diff_mag, tol_w, step_sum, floor_w;
  logic                 at_target;
  logic signed [PB-1:0] sat_move;
  logic signed [PB-1:0] right_next;

  assign cfg_ready = 1'b1;
  assign advance   = req_valid && (!out_valid || out_ready);
  assign in_ready  = !req_valid || advance;
  assign phase_out = phase;

  // Register writes; out-of-range indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      release_position   <= cps_pkg::RST_RELEASE_POS;
      extend_position    <= cps_pkg::RST_EXTEND_POS;
      retract_position   <= cps_pkg::RST_RETRACT_POS;
      deepest_position   <= cps_pkg::RST_DEEPEST_POS;
      step_delta         <= cps_pkg::RST_STEP_DELTA;
      release_wait_ticks <= cps_pkg::RST_WAIT_TICKS;
      near_tolerance     <= cps_pkg::RST_NEAR_TOL;
      far_tolerance      <= cps_pkg::RST_FAR_TOL;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cps_pkg::REG_RELEASE_POS: release_position   <= cfg_data;
        cps_pkg::REG_EXTEND_POS:  extend_position    <= cfg_data;
        cps_pkg::REG_RETRACT_POS: retract_position   <= cfg_data;
        cps_pkg::REG_DEEPEST_POS: deepest_position   <= cfg_data;
        cps_pkg::REG_STEP_DELTA:  step_delta         <= cfg_data[cps_pkg::STEP_BITS-1:0];
        cps_pkg::REG_WAIT_TICKS:  release_wait_ticks <= cfg_data[cps_pkg::WAIT_CFG_BITS-1:0];
        cps_pkg::REG_NEAR_TOL:    near_tolerance     <= cfg_data[cps_pkg::TOL_BITS-1:0];
        cps_pkg::REG_FAR_TOL:     far_tolerance      <= cfg_data[cps_pkg::TOL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register: holds one request until the result register can take its result.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      req_kind     <= kind;
      req_pressed  <= retract_pressed;
      req_released <= retract_released;
      req_position <= position;
    end
  end

  // Distance test against the stored target; the band depends on the target's sign.
  always_comb begin
    diff     = W'(req_position) - W'(current_target);
    diff_mag = (diff < 0) ? -diff : diff;
    tol_w    = (current_target >= 0) ? $signed(W'(near_tolerance)) : $signed(W'(far_tolerance));
    at_target = diff_mag < tol_w;
  end

  // Step target: position plus twice the step, not below the deepest position.
  always_comb begin
    step_sum = W'(req_position) + W'($signed({step_delta, 1'b0}));
    floor_w  = W'(deepest_position);
    if (step_sum < floor_w) step_sum = floor_w;
  end

  // Phase update for the request in the input register.
  always_comb begin
    phase_next      = phase;
    wait_count_next = wait_count;
    cmd_next        = cps_pkg::CMD_NONE;
    move            = '0;
    if (req_kind) begin
      wait_count_next = '0;
      phase_next      = RELEASE;
      cmd_next        = cps_pkg::CMD_ZERO;
    end else begin
      unique case (phase)
        IDLE: ;
        RELEASE: begin
          // No at-target check here: move out and go straight to the wait.
          cmd_next   = cps_pkg::CMD_MOVE;
          move       = W'(release_position);
          phase_next = WAIT;
        end
        WAIT: begin
          if (wait_count != cps_pkg::WAIT_MAX) wait_count_next = wait_count + 1'b1;
          if (wait_count > cps_pkg::WAIT_BITS'(release_wait_ticks)) begin
            phase_next = EXTEND;
            cmd_next   = cps_pkg::CMD_MOVE;
            move       = W'(extend_position);
          end
        end
        EXTEND: begin
          if (at_target) begin
            phase_next = HOLD;
            cmd_next   = cps_pkg::CMD_STOP;
          end
        end
        HOLD: begin
          if (req_pressed) begin
            phase_next = RETRACT;
            cmd_next   = cps_pkg::CMD_MOVE;
            move       = W'(retract_position);
          end
        end
        RETRACT: begin
          if (req_released || at_target) begin
            phase_next = HOLD_AGAIN;
            cmd_next   = cps_pkg::CMD_STOP;
          end
        end
        HOLD_AGAIN: begin
          if (req_pressed) phase_next = STEP;
        end
        STEP: begin
          if (req_released) begin
            phase_next = HOLD_AGAIN;
            cmd_next   = cps_pkg::CMD_STOP;
          end else begin
            cmd_next = cps_pkg::CMD_MOVE;
            move     = step_sum;
          end
        end
        default: ;
      endcase
    end
  end

  // Saturated target; the right side is its negation, with the most negative value clamped.
  always_comb begin
    sat_move            = cps_pkg::sat_pos(move);
    right_next          = cps_pkg::sat_pos(-W'(sat_move));
    current_target_next = (cmd_next == cps_pkg::CMD_MOVE) ? sat_move : current_target;
  end

  // State and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= IDLE;
      wait_count     <= '0;
      current_target <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (advance) begin
        phase          <= phase_next;
        wait_count     <= wait_count_next;
        current_target <= current_target_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      command      <= cmd_next;
      left_target  <= (cmd_next == cps_pkg::CMD_MOVE) ? sat_move : '0;
      right_target <= (cmd_next == cps_pkg::CMD_MOVE) ? right_next : '0;
    end
  end

endmodule

// ===== hw/rtl/cps_checker.sv =====
// Port-level checker for the climb sequencer and its bind statement.
module cps_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic [1:0]                              command,
  input logic signed [cps_pkg::POSITION_BITS-1:0] left_target,
  input logic signed [cps_pkg::POSITION_BITS-1:0] right_target,
  input logic [2:0]                              phase_out
);

  localparam logic signed [cps_pkg::POSITION_BITS-1:0] POS_MIN =
    {1'b1, {(cps_pkg::POSITION_BITS-1){1'b0}}};

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(command) && $stable(left_target)
      && $stable(right_target) && $stable(phase_out))
    else $error("stalled result changed");

  // Targets are zero unless moving.
  a_targets_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && command != cps_pkg::CMD_MOVE |-> left_target == '0 && right_target == '0)
    else $error("nonzero target without move");

  // Zeroing only comes with the start of release.
  a_zero_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == cps_pkg::CMD_ZERO |-> phase_out == cps_pkg::PH_RELEASE)
    else $error("zero command outside release");

  // Right target mirrors the left one, unless the left one is the most negative value.
  a_mirror: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == cps_pkg::CMD_MOVE && left_target != POS_MIN
      |-> right_target == -left_target)
    else $error("right target not mirrored");

endmodule

bind climb_position_sequencer cps_checker u_cps_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .command      (command),
  .left_target  (left_target),
  .right_target (right_target),
  .phase_out    (phase_out)
);

// ===== tb/climb_position_sequencer_tb.sv =====
// Self-checking testbench for the winch-climb position sequencer.
`timescale 1ns / 1ps

module climb_position_sequencer_tb;
  import cps_pkg::*;

  // Hard stop for a hung handshake.
  localparam int CYCLE_LIMIT = 400000;
  // Random requests per configuration round; six rounds plus the directed part
  // come to roughly 1450 requests that actually move the phase logic.
  localparam int ROUND_REQUESTS = 240;
  localparam int ROUNDS = 6;
  localparam int HOLD_OFF_CYCLES = 120;

  typedef struct {
    logic [1:0]                      command;
    logic signed [POSITION_BITS-1:0] left;
    logic signed [POSITION_BITS-1:0] right;
    logic [2:0]                      phase;
  } climb_result_t;

  // Mirrors the sequencer: registers, phase, wait counter and held target.
  // Every accepted request is run through the phase update at once and the
  // result it must produce is queued; results coming out of the block are
  // compared against the head of that queue.
  class climb_checker;
    logic signed [CFG_POS_BITS-1:0]  release_pos;
    logic signed [CFG_POS_BITS-1:0]  extend_pos;
    logic signed [CFG_POS_BITS-1:0]  retract_pos;
    logic signed [CFG_POS_BITS-1:0]  deepest_pos;
    logic signed [STEP_BITS-1:0]     step_delta;
    logic [WAIT_CFG_BITS-1:0]        wait_ticks;
    logic [TOL_BITS-1:0]             near_tol;
    logic [TOL_BITS-1:0]             far_tol;
    logic [2:0]                      phase;
    logic [WAIT_BITS-1:0]            wait_count;
    logic signed [POSITION_BITS-1:0] current_target;
    climb_result_t                   pending_results[$];
    int                              mismatch_count;

    function new();
      release_pos    = RST_RELEASE_POS;
      extend_pos     = RST_EXTEND_POS;
      retract_pos    = RST_RETRACT_POS;
      deepest_pos    = RST_DEEPEST_POS;
      step_delta     = RST_STEP_DELTA;
      wait_ticks     = RST_WAIT_TICKS;
      near_tol       = RST_NEAR_TOL;
      far_tol        = RST_FAR_TOL;
      phase          = PH_IDLE;
      wait_count     = '0;
      current_target = '0;
      mismatch_count = 0;
    endfunction

    static function logic signed [POSITION_BITS-1:0] clamp_position(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) << (POSITION_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return POSITION_BITS'(v);
    endfunction

    function longint band();
      return (current_target >= 0) ? longint'(near_tol) : longint'(far_tol);
    endfunction

    function bit on_target(logic signed [POSITION_BITS-1:0] pos);
      longint d;
      d = longint'(pos) - longint'(current_target);
      if (d < 0) d = -d;
      return d < band();
    endfunction

    // Only the low bits of each register are kept; unknown indexes fall away.
    function void write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_RELEASE_POS: release_pos = data[CFG_POS_BITS-1:0];
        REG_EXTEND_POS:  extend_pos  = data[CFG_POS_BITS-1:0];
        REG_RETRACT_POS: retract_pos = data[CFG_POS_BITS-1:0];
        REG_DEEPEST_POS: deepest_pos = data[CFG_POS_BITS-1:0];
        REG_STEP_DELTA:  step_delta  = data[STEP_BITS-1:0];
        REG_WAIT_TICKS:  wait_ticks  = data[WAIT_CFG_BITS-1:0];
        REG_NEAR_TOL:    near_tol    = data[TOL_BITS-1:0];
        REG_FAR_TOL:     far_tol     = data[TOL_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic k, logic pressed, logic released,
                               logic signed [POSITION_BITS-1:0] pos);
      climb_result_t r;
      longint        goal;
      longint        step_goal;
      int            count_was;
      r.command = CMD_NONE;
      goal = 0;
      if (k) begin
        wait_count = '0;
        phase      = PH_RELEASE;
        r.command  = CMD_ZERO;
      end else begin
        case (phase)
          PH_RELEASE: begin
            r.command = CMD_MOVE;
            goal      = longint'(release_pos);
            phase     = PH_WAIT;
          end
          PH_WAIT: begin
            count_was = int'(wait_count);
            if (wait_count != WAIT_MAX) wait_count = wait_count + 1'b1;
            if (count_was > int'(wait_ticks)) begin
              phase     = PH_EXTEND;
              r.command = CMD_MOVE;
              goal      = longint'(extend_pos);
            end
          end
          PH_EXTEND: begin
            if (on_target(pos)) begin
              phase     = PH_HOLD;
              r.command = CMD_STOP;
            end
          end
          PH_HOLD: begin
            if (pressed) begin
              phase     = PH_RETRACT;
              r.command = CMD_MOVE;
              goal      = longint'(retract_pos);
            end
          end
          PH_RETRACT: begin
            if (released || on_target(pos)) begin
              phase     = PH_HOLD_AGAIN;
              r.command = CMD_STOP;
            end
          end
          PH_HOLD_AGAIN: begin
            if (pressed) phase = PH_STEP;
          end
          PH_STEP: begin
            if (released) begin
              phase     = PH_HOLD_AGAIN;
              r.command = CMD_STOP;
            end else begin
              step_goal = longint'(pos) + 2 * longint'(step_delta);
              if (step_goal < longint'(deepest_pos)) step_goal = longint'(deepest_pos);
              r.command = CMD_MOVE;
              goal      = step_goal;
            end
          end
          default: ;
        endcase
      end
      r.left  = '0;
      r.right = '0;
      if (r.command == CMD_MOVE) begin
        current_target = clamp_position(goal);
        r.left         = current_target;
        r.right        = clamp_position(-longint'(current_target));
      end
      r.phase = phase;
      pending_results.push_back(r);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    task report(string msg);
      if (mismatch_count < 100) $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    task check_result(logic [1:0] cmd, logic signed [POSITION_BITS-1:0] left,
                      logic signed [POSITION_BITS-1:0] right, logic [2:0] ph);
      climb_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending: command %0d phase %0d", cmd, ph));
        return;
      end
      want = pending_results.pop_front();
      if (cmd !== want.command)
        report($sformatf("command %0d, expected %0d", cmd, want.command));
      if (left !== want.left)
        report($sformatf("left_target %0d, expected %0d", left, want.left));
      if (right !== want.right)
        report($sformatf("right_target %0d, expected %0d", right, want.right));
      if (ph !== want.phase)
        report($sformatf("phase_out %0d, expected %0d", ph, want.phase));
    endtask
  endclass

  logic                            clk;
  logic                            rst;
  logic                            in_valid;
  logic                            in_ready;
  logic                            kind;
  logic                            retract_pressed;
  logic                            retract_released;
  logic signed [POSITION_BITS-1:0] position;
  logic                            out_valid;
  logic                            out_ready;
  logic [1:0]                      command;
  logic signed [POSITION_BITS-1:0] left_target;
  logic signed [POSITION_BITS-1:0] right_target;
  logic [2:0]                      phase_out;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [CFG_IDX_BITS-1:0]         cfg_index;
  logic [CFG_DATA_BITS-1:0]        cfg_data;

  climb_checker sb = new();

  // Idle gaps on either side; cleared for one round to get a back-to-back stretch.
  bit in_gaps_on  = 1'b1;
  bit out_gaps_on = 1'b1;
  // Long receiver hold-offs are asked for by bumping this count.
  int hold_off_asks = 0;
  int cycle_count   = 0;

  climb_position_sequencer dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .retract_pressed  (retract_pressed),
    .retract_released (retract_released),
    .position         (position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .command          (command),
    .left_target      (left_target),
    .right_target     (right_target),
    .phase_out        (phase_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Result side. Outputs are sampled at the rising edge, so the block's own
  // register updates at that edge are not yet visible here.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(command, left_target, right_target, phase_out);
  end

  // Receiver: random back-pressure, plus a long hold-off whenever one is asked.
  // During a hold-off the sender keeps offering, so the input and result
  // registers both fill and in_ready has to drop.
  initial begin
    int hold_left;
    int hold_offs_served;
    hold_left        = 0;
    hold_offs_served = 0;
    out_ready        = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_asks != hold_offs_served) begin
        hold_offs_served++;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(out_gaps_on && $urandom_range(99) < 20);
      end
    end
  end

  // Offer one request, starting at a falling edge, and return at the falling
  // edge after it was taken. Valid is left high; the caller drops it when done.
  task automatic send_request(input logic k, input logic pressed, input logic released,
                              input logic signed [POSITION_BITS-1:0] pos);
    while (in_gaps_on && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    kind             <= k;
    retract_pressed  <= pressed;
    retract_released <= released;
    position         <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(k, pressed, released, pos);
    @(negedge clk);
  endtask

  // Register write; valid stays high so writes can go back to back.
  task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_register(idx, data);
    @(negedge clk);
  endtask

  // Sender pause: wait out every pending result, then let the input and result registers settle.
  task automatic drain_results();
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] random_setpoint();
    int roll;
    roll = $urandom_range(99);
    if (roll < 4)  return 24'h7FFFFF;
    if (roll < 8)  return 24'h800000;
    if (roll < 11) return 24'h000000;
    if (roll < 14) return 24'hFFFFFF;
    return CFG_DATA_BITS'(int'($urandom_range(80000)) - 40000);
  endfunction

  // Rounds 0 and 1 are the two corners; the rest draw at random. Upper data
  // bits above a register's width are filled with noise, which must be dropped.
  task automatic apply_setting(input int round);
    logic [CFG_DATA_BITS-1:0] v[8];
    if (round == 0) begin
      v[0] = 24'h7FFFFF;
      v[1] = 24'h7FFFFF;
      v[2] = 24'h800000;
      v[3] = 24'h7FFFFF;
      v[4] = 24'hFEFFFF;   // step +65535, a positive step outside the normal range
      v[5] = 24'hA5C3FF;   // longest wait
      v[6] = 24'h5AFFFF;
      v[7] = 24'hC3FFFF;
    end else if (round == 1) begin
      v[0] = 24'h800000;
      v[1] = 24'h800000;
      v[2] = 24'h000000;
      v[3] = 24'h800000;
      v[4] = 24'h010000;   // most negative step
      v[5] = 24'hFFFF00;   // no wait at all
      v[6] = 24'hFF0000;   // zero band: never on target for a non-negative goal
      v[7] = 24'h000001;   // exact hit only
    end else begin
      v[0] = random_setpoint();
      v[1] = random_setpoint();
      v[2] = random_setpoint();
      v[3] = random_setpoint();
      if ($urandom_range(99) < 15) v[4] = CFG_DATA_BITS'($urandom);
      else v[4] = {7'($urandom), 17'(-int'($urandom_range(2000)))};
      if ($urandom_range(99) < 20) v[5] = {16'($urandom), 8'($urandom_range(40))};
      else v[5] = {16'($urandom), 8'($urandom_range(6))};
      v[6] = {8'($urandom), 16'($urandom_range(3000, 50))};
      v[7] = {8'($urandom), 16'($urandom_range(3000, 50))};
      if ($urandom_range(99) < 10) v[6] = CFG_DATA_BITS'($urandom);
      if ($urandom_range(99) < 10) v[7] = CFG_DATA_BITS'($urandom);
    end
    write_register(REG_RELEASE_POS, v[0]);
    write_register(REG_EXTEND_POS,  v[1]);
    write_register(REG_RETRACT_POS, v[2]);
    write_register(REG_DEEPEST_POS, v[3]);
    write_register(REG_STEP_DELTA,  v[4]);
    write_register(REG_WAIT_TICKS,  v[5]);
    write_register(REG_NEAR_TOL,    v[6]);
    write_register(REG_FAR_TOL,     v[7]);
    // index past the register list: must change nothing
    write_register(CFG_IDX_BITS'($urandom_range(15, 8)), CFG_DATA_BITS'($urandom));
    cfg_valid <= 1'b0;
    repeat (2) @(negedge clk);
  endtask

  // Encoder position, steered at the interesting spots: around the held
  // target (at-target band edges), around the step floor, the range ends.
  function automatic logic signed [POSITION_BITS-1:0] pick_position(int near_pct);
    int     roll;
    longint b;
    roll = $urandom_range(99);
    if (roll < near_pct) begin
      b = sb.band() + 1;
      return climb_checker::clamp_position(longint'(sb.current_target) - b +
                                           longint'($urandom_range(2 * b)));
    end
    roll = $urandom_range(99);
    if (roll < 15)
      return climb_checker::clamp_position(longint'(sb.deepest_pos) -
                                           2 * longint'(sb.step_delta) +
                                           longint'($urandom_range(6)) - 3);
    if (roll < 20) return {1'b0, {(POSITION_BITS-1){1'b1}}};
    if (roll < 25) return {1'b1, {(POSITION_BITS-1){1'b0}}};
    if (roll < 28) return '0;
    return POSITION_BITS'($urandom);
  endfunction

  // Mostly well-formed climbs: starts when idle, button presses where the
  // sequence waits for them, positions near the goal where the block checks
  // for arrival. A few stray starts break sequences at every phase.
  task automatic pick_request(output logic k, output logic pressed, output logic released,
                              output logic signed [POSITION_BITS-1:0] pos);
    int roll;
    roll     = $urandom_range(99);
    k        = (roll < 3);
    pressed  = 1'($urandom_range(1));
    released = 1'($urandom_range(1));
    pos      = pick_position(10);
    case (sb.phase)
      PH_IDLE:       k = (roll < 70);
      PH_EXTEND:     pos = pick_position(50);
      PH_HOLD,
      PH_HOLD_AGAIN: pressed = ($urandom_range(99) < 35);
      PH_RETRACT: begin
        released = ($urandom_range(99) < 20);
        pos      = pick_position(40);
      end
      PH_STEP:       released = ($urandom_range(99) < 15);
      default: ;
    endcase
  endtask

  initial begin
    logic                            k;
    logic                            pressed;
    logic                            released;
    logic signed [POSITION_BITS-1:0] pos;
    int                              counted;
    rst              = 1'b1;
    in_valid         = 1'b0;
    kind             = 1'b0;
    retract_pressed  = 1'b0;
    retract_released = 1'b0;
    position         = '0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // Directed setting: no wait, deepest at the bottom of the range and a
    // step of -65535, so step targets hit the floor and the negated
    // most-negative target saturates.
    write_register(REG_RELEASE_POS, 24'd600);
    write_register(REG_EXTEND_POS,  24'(-20000));
    write_register(REG_RETRACT_POS, 24'(-25000));
    write_register(REG_DEEPEST_POS, 24'h800000);
    write_register(REG_STEP_DELTA,  24'h010001);   // -65535
    write_register(REG_WAIT_TICKS,  24'h000000);
    write_register(REG_NEAR_TOL,    24'd300);
    write_register(REG_FAR_TOL,     24'd1000);
    write_register(4'd9, 24'h123456);
    cfg_valid <= 1'b0;
    repeat (2) @(negedge clk);

    send_request(1'b0, 1'b1, 1'b1, 24'h7FFFFF);     // idle tick: ignored
    send_request(1'b1, 1'b1, 1'b0, 24'h000000);     // start: zero, phase to release
    send_request(1'b0, 1'b0, 1'b0, 24'h000000);     // release: move, no arrival check
    send_request(1'b0, 1'b1, 1'b1, 24'h000000);     // wait, count 0
    send_request(1'b0, 1'b0, 1'b0, 24'h000000);     // wait leaves: move to extend
    send_request(1'b0, 1'b0, 1'b0, 24'(-21000));    // band edge: not yet there
    send_request(1'b0, 1'b0, 1'b0, 24'(-20999));    // just inside: stop, hold
    send_request(1'b0, 1'b0, 1'b1, 24'h000000);     // hold, no press
    send_request(1'b0, 1'b1, 1'b0, 24'h000000);     // press: move to retract
    send_request(1'b0, 1'b0, 1'b0, 24'h000000);     // retracting, far away
    send_request(1'b0, 1'b0, 1'b1, 24'h000000);     // button up: stop
    send_request(1'b0, 1'b0, 1'b0, 24'h000000);     // hold again, no press
    send_request(1'b0, 1'b1, 1'b0, 24'h000000);     // press: step phase
    send_request(1'b0, 1'b0, 1'b0, 24'h800000);     // floored at range bottom
    send_request(1'b0, 1'b1, 1'b0, 24'h7FFFFF);     // top of range
    send_request(1'b0, 1'b0, 1'b0, 24'hFFFFFF);     // minus one
    send_request(1'b0, 1'b0, 1'b1, 24'h000000);     // button up: stop
    send_request(1'b0, 1'b1, 1'b0, 24'h000000);     // back to step
    send_request(1'b1, 1'b0, 1'b1, 24'h123456);     // start mid-step
    send_request(1'b0, 1'b0, 1'b0, 24'h000000);     // release again
    send_request(1'b0, 1'b0, 1'b0, 24'h000000);
    send_request(1'b0, 1'b0, 1'b0, 24'h000000);     // extend again
    send_request(1'b0, 1'b0, 1'b0, 24'(-20000));    // exactly on target
    in_valid <= 1'b0;
    drain_results();

    for (int round = 0; round < ROUNDS; round++) begin
      apply_setting(round);
      // one round runs with no idling on either side
      in_gaps_on  = (round != 3);
      out_gaps_on = (round != 3);
      if (round == 2 || round == 4) hold_off_asks++;
      counted = 0;
      while (counted < ROUND_REQUESTS) begin
        pick_request(k, pressed, released, pos);
        if (k || sb.phase != PH_IDLE) counted++;
        send_request(k, pressed, released, pos);
      end
      in_valid <= 1'b0;
      drain_results();
    end

    // Pipe is two deep; give it a few more cycles to show any stray result.
    repeat (8) @(negedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    if (sb.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
